### rtl/core/dq_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dq_pkg: shared types and constants for the double-ended byte queue
// Request and response payloads, command and status codes, and the shift
// controls handed to every storage cell of the queue.
// ---------------------------------------------------------------------------
package dq_pkg;

    // Queue geometry
    localparam int DEPTH  = 64;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int BYTE_W = 8;
    localparam int CMD_W  = 3;
    localparam int FILL_W = 7;

    // Command codes; the two remaining codes are a no-operation
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PEEK_REAR  = 3'd5;

    // Response status
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] push_byte;
    } dq_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] result_byte;
        status_t           status;
        logic [FILL_W-1:0] fill_count;
        logic              is_empty;
    } dq_rsp_t;

    // Row-wide shift controls, at most one set per cycle
    typedef struct packed {
        logic push_front;
        logic push_rear;
        logic pop_front;
        logic pop_rear;
    } dq_shift_t;

endpackage
`default_nettype wire

### rtl/core/dq_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dq_cell: one storage cell of the queue row
// Holds one byte and an occupied flag. Entries sit packed from cell 0 (the
// front); pushes and pops at the front shift the whole row by one place,
// while rear operations touch only the cell on the boundary.
// ---------------------------------------------------------------------------
module dq_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire dq_pkg::dq_shift_t         ctl,
    input  wire logic [dq_pkg::BYTE_W-1:0] push_byte,
    input  wire logic                      left_occ,
    input  wire logic [dq_pkg::BYTE_W-1:0] left_data,
    input  wire logic                      right_occ,
    input  wire logic [dq_pkg::BYTE_W-1:0] right_data,
    output logic                           occ,
    output logic [dq_pkg::BYTE_W-1:0]      data,
    output logic [dq_pkg::BYTE_W-1:0]      rear_tap
);
    import dq_pkg::*;

    logic              occ_reg;
    logic              occ_next;
    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] data_next;
    logic              is_last;
    logic              is_slot;

    // Boundary cells for rear operations
    assign is_last = occ_reg && !right_occ;
    assign is_slot = !occ_reg && left_occ;

    // Choose this cell's next contents
    always_comb
    begin
        occ_next  = occ_reg;
        data_next = data_reg;
        priority if (ctl.push_front)
        begin
            occ_next  = left_occ;
            data_next = left_data;
        end
        else if (ctl.pop_front)
        begin
            occ_next  = right_occ;
            data_next = right_data;
        end
        else if (ctl.push_rear && is_slot)
        begin
            occ_next  = 1'b1;
            data_next = push_byte;
        end
        else if (ctl.pop_rear && is_last)
        begin
            occ_next = 1'b0;
        end
        else
        begin
            // Hold the cell as it is
            occ_next  = occ_reg;
            data_next = data_reg;
        end
    end

    // Hold occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // Hold the byte
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign occ      = occ_reg;
    assign data     = data_reg;
    assign rear_tap = is_last ? data_reg : '0;

endmodule
`default_nettype wire

### rtl/core/double_ended_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// double_ended_queue: byte-wide double-ended queue of DEPTH entries
// Push, pop and peek at either end, one response per request.
// ---------------------------------------------------------------------------
// A new request is taken every cycle while responses are taken: the whole
// operation is one update of the cell row, where front pushes and pops shift
// every cell by one place and rear operations act on the cell at the occupied
// boundary. The response sits in an output register in the cycle after its
// request is taken; a new request is taken in the same cycle as the waiting
// response is taken, and while a response waits unread the request side is
// held off. After reset the queue is empty at once; there is no clearing pass.
// Pops and peeks on an empty queue are refused with status empty, pushes on a
// full queue with status full; both leave the queue as it was and return a
// zero byte. The two unused command codes do nothing.
module double_ended_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire dq_pkg::dq_req_t req,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output dq_pkg::dq_rsp_t      rsp
);
    import dq_pkg::*;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              rsp_valid_reg;
    dq_rsp_t           rsp_reg;
    dq_rsp_t           rsp_next;
    dq_shift_t         op;
    dq_shift_t         ctl;
    logic              accept;
    logic              empty;
    logic              full;
    logic [BYTE_W-1:0] rear_byte;

    logic              occ_w  [DEPTH];
    logic [BYTE_W-1:0] data_w [DEPTH];
    logic [BYTE_W-1:0] tap_w  [DEPTH];

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;

    // Gather the rear byte from the boundary cell
    always_comb
    begin
        rear_byte = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rear_byte = rear_byte | tap_w[i];
        end
    end

    // Decode the request
    always_comb
    begin
        op                   = '0;
        count_next           = count_reg;
        rsp_next.result_byte = '0;
        rsp_next.status      = ST_DONE;
        unique case (req.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_REAR:
            begin
                if (full)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    op.push_front        = (req.cmd == CMD_PUSH_FRONT);
                    op.push_rear         = (req.cmd == CMD_PUSH_REAR);
                    count_next           = count_reg + CNT_W'(1);
                    rsp_next.result_byte = req.push_byte;
                end
            end
            CMD_POP_FRONT, CMD_PEEK_FRONT:
            begin
                if (empty)
                begin
                    rsp_next.status = ST_EMPTY;
                end
                else
                begin
                    rsp_next.result_byte = data_w[0];
                    if (req.cmd == CMD_POP_FRONT)
                    begin
                        op.pop_front = 1'b1;
                        count_next   = count_reg - CNT_W'(1);
                    end
                end
            end
            CMD_POP_REAR, CMD_PEEK_REAR:
            begin
                if (empty)
                begin
                    rsp_next.status = ST_EMPTY;
                end
                else
                begin
                    rsp_next.result_byte = rear_byte;
                    if (req.cmd == CMD_POP_REAR)
                    begin
                        op.pop_rear = 1'b1;
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                op = '0;
            end
        endcase
        rsp_next.fill_count = FILL_W'(count_next);
        rsp_next.is_empty   = (count_next == '0);
    end

    assign ctl = accept ? op : '0;

    // Row of storage cells, front at cell 0
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic              l_occ;
        logic [BYTE_W-1:0] l_data;
        logic              r_occ;
        logic [BYTE_W-1:0] r_data;

        if (g == 0)
        begin : g_head
            assign l_occ  = 1'b1;
            assign l_data = req.push_byte;
        end
        else
        begin : g_body
            assign l_occ  = occ_w[g-1];
            assign l_data = data_w[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_tail
            assign r_occ  = 1'b0;
            assign r_data = data_w[g];
        end
        else
        begin : g_inner
            assign r_occ  = occ_w[g+1];
            assign r_data = data_w[g+1];
        end

        dq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .push_byte  (req.push_byte),
            .left_occ   (l_occ),
            .left_data  (l_data),
            .right_occ  (r_occ),
            .right_data (r_data),
            .occ        (occ_w[g]),
            .data       (data_w[g]),
            .rear_tap   (tap_w[g])
        );
    end

    // Hold count and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the response of an accepted request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Front cell is occupied exactly when the count is non-zero
    a_front_occ: assert property (@(posedge clk) disable iff (!rst_n)
        occ_w[0] == (count_reg != '0))
        else $error("front cell occupancy disagrees with count");

    // Last cell is occupied exactly when the queue is full
    a_tail_occ: assert property (@(posedge clk) disable iff (!rst_n)
        occ_w[DEPTH-1] == (count_reg == CNT_W'(DEPTH)))
        else $error("last cell occupancy disagrees with count");

    // A refused push reports a full queue
    a_full_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_reg.status == ST_FULL)
        |-> (rsp_reg.fill_count == FILL_W'(DEPTH)) && !rsp_reg.is_empty)
        else $error("full refusal with wrong count");

    // A refused pop or peek reports an empty queue and a zero byte
    a_empty_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_reg.status == ST_EMPTY)
        |-> rsp_reg.is_empty && (rsp_reg.result_byte == '0))
        else $error("empty refusal with wrong payload");

    // A push raises the count by one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (ctl.push_front || ctl.push_rear)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not raise the count");

endmodule
`default_nettype wire
